/* src/bgc_pkg.sv */
// Shared codes, types and defaults for the button gesture classifier.
package bgc_pkg;

  typedef logic [2:0] action_t;
  typedef logic [1:0] kind_t;

  localparam action_t ACT_NONE     = 3'd0;
  localparam action_t ACT_PRESSED  = 3'd1;
  localparam action_t ACT_RELEASED = 3'd2;
  localparam action_t ACT_TAP      = 3'd3;
  localparam action_t ACT_TAP_ON   = 3'd4;
  localparam action_t ACT_DOUBLE   = 3'd5;
  localparam action_t ACT_FLIP_ON  = 3'd6;
  localparam action_t ACT_FLIP_OFF = 3'd7;

  localparam kind_t KIND_UNCHANGED = 2'd0;
  localparam kind_t KIND_BOUNCE    = 2'd1;
  localparam kind_t KIND_EDGE      = 2'd2;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_WINDOW = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOCKING    = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_HI  = 2'd3;

  localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CFG_DATA_BITS-1:0] TAP_WINDOW_RESET = 16'd400;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int IN_TIME_BITS      = 32;

endpackage

/* src/button_gesture_classifier_core.sv */
// Button gesture classifier: debounce, tap, double tap and flip detection.
//
// Each input beat is one level-change event of a button pin (level plus a
// free-running millisecond timestamp). The block sorts it as unchanged,
// bounce or accepted edge and returns exactly one result beat holding the
// latest action, the event kind and the current pressed status. An event
// is captured in the input register, then the classifier and state update
// run in one pass into the result register. A new event is taken every
// cycle unless the result side holds it back; each state update is in
// place before the next event is classified. A held result stalls input
// only when both the input and result registers are full. Configuration
// (debounce time, tap window, locking mode, polarity) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while no event
// is in flight (the block does not enforce this). active_high only changes
// how stored levels are read. Gaps are (now - last edge) modulo 2^TIME_BITS.
module button_gesture_classifier_core #(
  parameter int TIME_BITS = bgc_pkg::TIME_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [bgc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bgc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // event input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               level,
  input  logic [bgc_pkg::IN_TIME_BITS-1:0]   time_ms,
  // result output
  output logic                               out_valid,
  input  logic                               out_ready,
  output bgc_pkg::action_t                   action,
  output bgc_pkg::kind_t                     event_kind,
  output logic                               is_pressed
);
  import bgc_pkg::*;

  localparam int EXT_BITS = (TIME_BITS > IN_TIME_BITS) ? TIME_BITS : IN_TIME_BITS;

  // configuration
  logic [CFG_DATA_BITS-1:0] debounce_ms;
  logic [CFG_DATA_BITS-1:0] tap_window_ms;
  logic                     locking_mode;
  logic                     active_high;

  // classifier state
  logic                 current_level, current_level_next;
  logic                 previous_level, previous_level_next;
  logic [TIME_BITS-1:0] last_edge_time, last_edge_time_next;
  action_t              latest_action, latest_action_next;
  action_t              saved_action, saved_action_next;

  // input register
  logic                    s1_valid;
  logic                    s1_level;
  logic [IN_TIME_BITS-1:0] s1_time;

  logic s1_advance;
  kind_t kind_c;

  // result side frees up when empty or being drained
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_RESET;
      tap_window_ms <= TAP_WINDOW_RESET;
      locking_mode  <= 1'b0;
      active_high   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_ms   <= cfg_data;
        REG_TAP_WINDOW: tap_window_ms <= cfg_data;
        REG_LOCKING:    locking_mode  <= cfg_data[0];
        REG_ACTIVE_HI:  active_high   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level <= level;
      s1_time  <= time_ms;
    end
  end

  // ---- classification ----
  logic [EXT_BITS-1:0]  time_ext;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] gap;
  logic                 is_bounce, quick;
  logic                 np, cp, pp;
  action_t              restored;

  assign time_ext  = EXT_BITS'(s1_time);
  assign now       = time_ext[TIME_BITS-1:0];
  assign gap       = now - last_edge_time;
  assign is_bounce = gap < TIME_BITS'(debounce_ms);
  assign quick     = gap < TIME_BITS'(tap_window_ms);

  // pressed when the level matches the polarity
  assign np = (s1_level == active_high);
  assign cp = (current_level == active_high);
  assign pp = (previous_level == active_high);

  assign restored = (saved_action != ACT_NONE) ? saved_action : latest_action;

  always_comb begin
    current_level_next  = current_level;
    previous_level_next = previous_level;
    last_edge_time_next = last_edge_time;
    latest_action_next  = latest_action;
    saved_action_next   = saved_action;
    kind_c              = KIND_UNCHANGED;
    if (s1_level != current_level) begin
      if (is_bounce) begin
        kind_c = KIND_BOUNCE;
        // save once; a saved none reads as nothing saved
        if (saved_action == ACT_NONE) begin
          saved_action_next = latest_action;
        end
        latest_action_next = np ? ACT_PRESSED : ACT_RELEASED;
        current_level_next = s1_level;
      end else begin
        kind_c            = KIND_EDGE;
        saved_action_next = ACT_NONE;
        latest_action_next = restored;
        if (np && !cp && pp && quick) begin
          latest_action_next = locking_mode ? ACT_FLIP_ON : ACT_TAP_ON;
        end else if (!np && cp && !pp && quick) begin
          if (locking_mode) begin
            latest_action_next = ACT_FLIP_OFF;
          end else begin
            latest_action_next = (restored == ACT_TAP_ON) ? ACT_DOUBLE : ACT_TAP;
          end
        end else if (cp && !np) begin
          latest_action_next = ACT_RELEASED;
        end else if (!cp && np) begin
          latest_action_next = ACT_PRESSED;
        end
        last_edge_time_next = now;
        previous_level_next = current_level;
        current_level_next  = s1_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level  <= 1'b1;
      previous_level <= 1'b0;
      last_edge_time <= '0;
      latest_action  <= ACT_NONE;
      saved_action   <= ACT_NONE;
    end else if (s1_advance) begin
      current_level  <= current_level_next;
      previous_level <= previous_level_next;
      last_edge_time <= last_edge_time_next;
      latest_action  <= latest_action_next;
      saved_action   <= saved_action_next;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      action     <= latest_action_next;
      event_kind <= kind_c;
      is_pressed <= (current_level_next == active_high);
    end
  end

  // ---- assertions ----
  a_bounce_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_BOUNCE |->
      action == ACT_PRESSED || action == ACT_RELEASED)
    else $error("bounce result carries a gesture action");

  a_edge_clears_saved: assert property (@(posedge clk) disable iff (rst)
    s1_advance && kind_c == KIND_EDGE |=> saved_action == ACT_NONE)
    else $error("saved action survived an accepted edge");

  a_edge_has_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_EDGE |-> action != ACT_NONE)
    else $error("accepted edge left no action");

endmodule
